// File: rtl/wbps_pkg.sv
// Shared types, constants and helpers of the wildcard byte pattern scan core.
`default_nettype none

package wbps_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_SCAN = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_BASE_ADDRESS   = 2'd1,
    CFG_RESULT_OFFSET  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [IDX_W-1:0]   pattern_index;
    logic [BYTE_W-1:0]  pattern_byte;
    logic               wildcard_req;
    logic [BYTE_W-1:0]  data_byte;
    logic               last_byte;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  match_address;
  } res_t;

  typedef struct packed {
    logic               wild;
    logic [BYTE_W-1:0]  value;
  } pat_entry_t;

  typedef struct packed {
    logic shift_en;
    logic pat_we;
    logic active;
  } cell_ctrl_t;

  // Map a raw length onto 1 .. max_len.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                 input int unsigned max_len);
    logic [LEN_W-1:0] r;
    if (raw == '0) begin
      r = LEN_W'(1);
    end else if (32'(raw) > max_len) begin
      r = LEN_W'(max_len);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wbps_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface wbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/wbps_cell.sv
// One window cell: a byte of history, an aligned pattern entry and its compare.
`default_nettype none

module wbps_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wbps_pkg::cell_ctrl_t                  ctrl_i,
  input  logic [wbps_pkg::BYTE_W-1:0]           byte_i,
  input  wbps_pkg::pat_entry_t                  pat_i,
  output logic [wbps_pkg::BYTE_W-1:0]           byte_o,
  output logic                                  hit_o
);

  logic [wbps_pkg::BYTE_W-1:0] win_q;
  wbps_pkg::pat_entry_t        pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.shift_en) begin
      win_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_we) begin
      pat_q <= pat_i;
    end
  end

  assign byte_o = win_q;
  // Cells past the pattern length always agree.
  assign hit_o  = !ctrl_i.active || pat_q.wild || (pat_q.value == win_q);

endmodule

`default_nettype wire

// File: rtl/wildcard_byte_pattern_scan_core.sv
// Top level: wildcard byte pattern scan over a chain of window cells.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  req_i   | in  | valid/ready          | load entry or scan byte (wbps_pkg::req_t)
//  res_o   | out | valid/ready          | found flag and match address (res_t)
//  cfg     | in  | cfg_we_i, no wait    | cfg_idx_i selects, cfg_wdata_i data
//
// One item per cycle while the compare stage does not stall: each scan byte shifts the
// cell chain at its transaction and is compared across all cells in the next cycle; a
// result is registered as the compare stage advances. The compare stage stalls, and ready
// drops, only while it holds a result and the output register is full and not taken.
// Reset acts at once: it clears the window, byte count, base, offset and flags; length goes to one.
`default_nettype none

module wildcard_byte_pattern_scan_core #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  wbps_stream_if.sink                          req_i,
  wbps_stream_if.source                        res_o
);

  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Configuration registers
  logic [wbps_pkg::LEN_W-1:0]  len_q;
  logic [wbps_pkg::ADDR_W-1:0] base_q;
  logic [wbps_pkg::OFF_W-1:0]  off_q;
  logic                        len_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= wbps_pkg::LEN_W'(1);
      base_q <= '0;
      off_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbps_pkg::CFG_PATTERN_LENGTH: len_q  <= cfg_wdata_i[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_BASE_ADDRESS:   base_q <= cfg_wdata_i;
        wbps_pkg::CFG_RESULT_OFFSET:  off_q  <= cfg_wdata_i[wbps_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_wr = cfg_we_i && (cfg_idx_i == wbps_pkg::CFG_PATTERN_LENGTH);

  logic [wbps_pkg::LEN_W-1:0] len_used;
  assign len_used = wbps_pkg::clamp_len(len_q, PATTERN_MAX);

  // Input decode
  wbps_pkg::req_t req;
  logic           req_ready;
  logic           req_acc;
  logic           load_acc;
  logic           scan_acc;

  assign req      = req_i.payload;
  assign req_acc  = req_i.valid && req_ready;
  assign load_acc = req_acc && (req.req_type == wbps_pkg::REQ_LOAD);
  assign scan_acc = req_acc && (req.req_type == wbps_pkg::REQ_SCAN);
  assign req_i.ready = req_ready;

  wbps_pkg::pat_entry_t load_entry;
  assign load_entry.wild  = req.wildcard_req;
  assign load_entry.value = req.pattern_byte;

  // Pattern store in written order
  wbps_pkg::pat_entry_t pat_q [PATTERN_MAX];

  for (genvar e = 0; e < PATTERN_MAX; e++) begin : g_pat
    always_ff @(posedge clk_i) begin
      if (load_acc && (32'(req.pattern_index) == e)) begin
        pat_q[e] <= load_entry;
      end
    end
  end

  // Realign the whole pattern to a new length: cell k takes entry len-1-k
  logic [wbps_pkg::LEN_W-1:0] rb_len;
  logic [AW-1:0]              rb_amt;
  wbps_pkg::pat_entry_t       shf [AW+1][PATTERN_MAX];

  assign rb_len = wbps_pkg::clamp_len(cfg_wdata_i[wbps_pkg::LEN_W-1:0], PATTERN_MAX);
  assign rb_amt = AW'(PATTERN_MAX - 32'(rb_len));

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      shf[0][k] = pat_q[PATTERN_MAX-1-k];
    end
    for (int s = 0; s < AW; s++) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (rb_amt[s] && (k + (1 << s) < PATTERN_MAX)) begin
          shf[s+1][k] = shf[s][k + (1 << s)];
        end else begin
          shf[s+1][k] = shf[s][k];
        end
      end
    end
  end

  // Aligned slot of a single loaded entry
  logic [wbps_pkg::LEN_W:0] load_tgt;
  logic                     load_in_len;

  assign load_tgt    = {1'b0, len_used} - (wbps_pkg::LEN_W+1)'(1)
                       - (wbps_pkg::LEN_W+1)'(req.pattern_index);
  assign load_in_len = (wbps_pkg::LEN_W'(req.pattern_index) < len_used);

  // Cell chain
  logic [wbps_pkg::BYTE_W-1:0] chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0]      hit;

  assign chain[0] = req.data_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wbps_pkg::cell_ctrl_t ctrl;
    wbps_pkg::pat_entry_t cell_pat;

    assign ctrl.shift_en = scan_acc;
    assign ctrl.pat_we   = len_wr || (load_acc && load_in_len && (32'(load_tgt) == k));
    assign ctrl.active   = (32'(len_used) > k);
    assign cell_pat      = len_wr ? shf[AW][k] : load_entry;

    wbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (chain[k]),
      .pat_i  (cell_pat),
      .byte_o (chain[k+1]),
      .hit_o  (hit[k])
    );
  end

  // Region byte count and compare stage
  logic [wbps_pkg::ADDR_W-1:0] seen_q;
  logic                        s1_valid_q;
  logic                        s1_last_q;
  logic                        s1_cond_q;
  logic [wbps_pkg::ADDR_W-1:0] s1_start_q;
  logic                        mr_q;

  logic                        s1_hit;
  logic                        s1_res;
  logic                        s1_adv;
  logic                        out_free;
  logic                        out_valid_q;
  wbps_pkg::res_t              out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (scan_acc) begin
      seen_q <= req.last_byte ? '0 : seen_q + wbps_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_acc) begin
      s1_last_q  <= req.last_byte;
      s1_cond_q  <= seen_q >= wbps_pkg::ADDR_W'(len_used - wbps_pkg::LEN_W'(1));
      s1_start_q <= seen_q + wbps_pkg::ADDR_W'(1) - wbps_pkg::ADDR_W'(len_used);
    end
  end

  assign s1_hit   = s1_valid_q && !mr_q && s1_cond_q && (&hit);
  assign s1_res   = s1_hit || (s1_valid_q && s1_last_q && !mr_q);
  assign out_free = !out_valid_q || res_o.ready;
  assign s1_adv   = !s1_res || out_free;
  assign req_ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mr_q       <= 1'b0;
    end else begin
      if (scan_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      // Set the reported flag on a hit; clear it at the end of each region
      if (s1_valid_q && s1_adv) begin
        mr_q <= s1_last_q ? 1'b0 : (mr_q || s1_hit);
      end
    end
  end

  // Output register
  logic [wbps_pkg::ADDR_W-1:0] addr_sum;

  assign addr_sum = base_q + s1_start_q
                    + {{(wbps_pkg::ADDR_W-wbps_pkg::OFF_W){off_q[wbps_pkg::OFF_W-1]}}, off_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_res && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_res && out_free) begin
      out_q.found         <= s1_hit;
      out_q.match_address <= s1_hit ? addr_sum : '0;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

`default_nettype wire

// File: rtl/wbps_port_chk.sv
// Port-level checks of the scan core, attached to the top level by bind.
`default_nettype none

module wbps_port_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  wbps_pkg::req_type_e           req_type_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic                          found_i,
  input  logic [wbps_pkg::ADDR_W-1:0]   match_address_i
);

  // Hold a pending result until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transaction");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !found_i |-> match_address_i == '0)
    else $error("not-found result carries an address");

  // A new result traces back to an accepted scan byte
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(req_valid_i && req_ready_i
                                 && (req_type_i == wbps_pkg::REQ_SCAN), 2))
    else $error("result without a preceding scan byte");

  // Drop ready only under output back-pressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind wildcard_byte_pattern_scan_core wbps_port_chk u_port_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_type_i      (req_i.payload.req_type),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .found_i         (res_o.payload.found),
  .match_address_i (res_o.payload.match_address)
);

`default_nettype wire

// File: tb/sv/wildcard_byte_pattern_scan_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the wildcard byte pattern scan core.

module wildcard_byte_pattern_scan_core_tb;

  localparam int unsigned PAT_MAX       = 64;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 160;

  // Tracks the pattern, the byte window and the region state; queues the
  // scan results the core owes and compares them as they arrive.
  class match_tracker;
    logic [7:0]     pat_val  [PAT_MAX];
    bit             pat_wild [PAT_MAX];
    logic [7:0]     window   [PAT_MAX];
    logic [63:0]    bytes_seen;
    bit             reported;
    logic [6:0]     len_reg;
    logic [63:0]    base_reg;
    logic [31:0]    offset_reg;
    wbps_pkg::res_t due_results[$];
    int             mismatches;
    int             found_seen;
    int             missed_seen;

    function new();
      foreach (pat_val[k]) begin
        pat_val[k]  = '0;
        pat_wild[k] = 1'b0;
        window[k]   = '0;
      end
      bytes_seen  = '0;
      reported    = 1'b0;
      len_reg     = 7'd1;
      base_reg    = '0;
      offset_reg  = '0;
      mismatches  = 0;
      found_seen  = 0;
      missed_seen = 0;
    endfunction

    function void write_reg(wbps_pkg::cfg_idx_e idx, logic [63:0] val);
      case (idx)
        wbps_pkg::CFG_PATTERN_LENGTH: len_reg = val[6:0];
        wbps_pkg::CFG_BASE_ADDRESS:   base_reg = val;
        wbps_pkg::CFG_RESULT_OFFSET:  offset_reg = val[31:0];
        default: ;
      endcase
    endfunction

    function int active_len();
      if (len_reg == '0) return 1;
      if (int'(len_reg) > PAT_MAX) return PAT_MAX;
      return int'(len_reg);
    endfunction

    function void absorb_item(wbps_pkg::req_t item);
      int             len;
      logic [63:0]    prior;
      bit             hit;
      wbps_pkg::res_t res;
      if (item.req_type == wbps_pkg::REQ_LOAD) begin
        pat_val[item.pattern_index]  = item.pattern_byte;
        pat_wild[item.pattern_index] = item.wildcard_req;
        return;
      end
      len   = active_len();
      prior = bytes_seen;
      for (int k = PAT_MAX - 1; k > 0; k--) window[k] = window[k - 1];
      window[0]  = item.data_byte;
      bytes_seen = prior + 64'd1;
      if (!reported && prior >= 64'(len - 1)) begin
        hit = 1'b1;
        // Entry 0 lines up with the oldest byte of the window.
        for (int j = 0; j < len; j++) begin
          if (!pat_wild[j] && pat_val[j] != window[len - 1 - j]) hit = 1'b0;
        end
        if (hit) begin
          res.found         = 1'b1;
          res.match_address = base_reg + (prior + 64'd1 - 64'(len))
                              + {{32{offset_reg[31]}}, offset_reg};
          due_results.push_back(res);
          reported = 1'b1;
        end
      end
      if (item.last_byte) begin
        if (!reported) begin
          res = '0;
          due_results.push_back(res);
        end
        bytes_seen = '0;
        reported   = 1'b0;
      end
    endfunction

    function void check_result(wbps_pkg::res_t got);
      wbps_pkg::res_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: found=%0b match_address=%h",
               got.found, got.match_address);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (want.found) found_seen++;
      else missed_seen++;
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        mismatches++;
      end
      if (got.match_address !== want.match_address) begin
        $error("match_address: expected %h, actual %h",
               want.match_address, got.match_address);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  wbps_stream_if #(.payload_t(wbps_pkg::req_t)) req_if ();
  wbps_stream_if #(.payload_t(wbps_pkg::res_t)) res_if ();

  wildcard_byte_pattern_scan_core #(
    .PATTERN_MAX(PAT_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  match_tracker tracker = new();
  int unsigned  cycle_count = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           hold_req = 0;
  int           item_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  // Result side: check every transaction, stall at random, and serve long holds.
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) tracker.check_result(res_if.payload);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic wbps_pkg::req_t load_req(input int idx, input logic [7:0] val,
                                              input bit wild);
    wbps_pkg::req_t r;
    r.req_type      = wbps_pkg::REQ_LOAD;
    r.pattern_index = wbps_pkg::IDX_W'(idx);
    r.pattern_byte  = val;
    r.wildcard_req  = wild;
    r.data_byte     = 8'($urandom);
    r.last_byte     = 1'($urandom);
    return r;
  endfunction

  function automatic wbps_pkg::req_t scan_req(input logic [7:0] val, input bit last);
    wbps_pkg::req_t r;
    r.req_type      = wbps_pkg::REQ_SCAN;
    r.pattern_index = wbps_pkg::IDX_W'($urandom);
    r.pattern_byte  = 8'($urandom);
    r.wildcard_req  = 1'($urandom);
    r.data_byte     = val;
    r.last_byte     = last;
    return r;
  endfunction

  task automatic send_item(input wbps_pkg::req_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.absorb_item(item);
    item_count++;
  endtask

  // Drop valid, drain all owed results, then let the pipeline go quiet.
  task automatic quiesce();
    req_if.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [6:0] len, input logic [63:0] base,
                              input logic [31:0] off);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= wbps_pkg::CFG_PATTERN_LENGTH;
    cfg_wdata_i <= 64'(len);
    @(posedge clk_i);
    tracker.write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'(len));
    cfg_idx_i   <= wbps_pkg::CFG_BASE_ADDRESS;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    tracker.write_reg(wbps_pkg::CFG_BASE_ADDRESS, base);
    cfg_idx_i   <= wbps_pkg::CFG_RESULT_OFFSET;
    cfg_wdata_i <= 64'(off);
    @(posedge clk_i);
    tracker.write_reg(wbps_pkg::CFG_RESULT_OFFSET, 64'(off));
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_directed();
    program_regs(7'd1, 64'h0000_0000_0000_1000, 32'hFFFF_FFFF);
    send_item(load_req(0, 8'hFF, 1'b0));
    // 0x7F must not match 0xFF: compare unsigned.
    send_item(scan_req(8'h7F, 1'b0));
    send_item(scan_req(8'hFF, 1'b0));
    // Bytes after the match stay silent, including the closing one.
    send_item(scan_req(8'h00, 1'b0));
    send_item(scan_req(8'hFF, 1'b1));
    send_item(scan_req(8'h80, 1'b1));
    quiesce();
    // Zero length acts as one; match on the final byte with address wrap.
    program_regs(7'd0, '1, 32'h7FFF_FFFF);
    send_item(scan_req(8'hFF, 1'b1));
    quiesce();
    program_regs(7'd3, '1, 32'h7FFF_FFFF);
    send_item(load_req(1, 8'hAB, 1'b1));
    send_item(load_req(2, 8'h00, 1'b0));
    // Region shorter than the pattern.
    send_item(scan_req(8'hFF, 1'b0));
    send_item(scan_req(8'h11, 1'b1));
    // Last possible start position, on the final byte.
    send_item(scan_req(8'hFF, 1'b0));
    send_item(scan_req(8'h22, 1'b0));
    send_item(scan_req(8'h00, 1'b1));
    // Pattern rewrite in the middle of a region.
    send_item(scan_req(8'h01, 1'b0));
    send_item(load_req(2, 8'h01, 1'b0));
    send_item(scan_req(8'hFF, 1'b0));
    send_item(scan_req(8'h05, 1'b0));
    send_item(scan_req(8'h01, 1'b1));
    send_item(load_req(2, 8'h00, 1'b0));
    // Register change while a region is open.
    send_item(scan_req(8'h10, 1'b0));
    send_item(scan_req(8'hFF, 1'b0));
    quiesce();
    program_regs(7'd3, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(scan_req(8'h33, 1'b0));
    send_item(scan_req(8'h00, 1'b1));
  endtask

  task automatic scan_region(input int eff, inout int phase_bytes);
    int         span;
    int         at;
    int         kind;
    int         j;
    bit         narrow;
    logic [7:0] bytes_q[$];
    kind = $urandom_range(9);
    if (kind == 0 && eff > 1) span = $urandom_range(eff - 1, 1);
    else span = eff + $urandom_range(12);
    narrow = 1'($urandom);
    // Narrow regions draw from the pattern's own bytes to provoke stray matches.
    for (int k = 0; k < span; k++) begin
      bytes_q.push_back(narrow ? tracker.pat_val[$urandom_range(eff - 1)] : 8'($urandom));
    end
    if (span >= eff && kind >= 1 && kind <= 6) begin
      at = (kind == 1) ? span - eff : $urandom_range(span - eff);
      for (int k = 0; k < eff; k++) begin
        if (!tracker.pat_wild[k]) bytes_q[at + k] = tracker.pat_val[k];
      end
      // Break the embedded copy in one byte for a near miss.
      if (kind == 6) begin
        j = $urandom_range(eff - 1);
        if (!tracker.pat_wild[j]) bytes_q[at + j] ^= 8'(1 << $urandom_range(7));
      end
    end
    for (int k = 0; k < span; k++) begin
      if ($urandom_range(23) == 0) begin
        send_item(load_req($urandom_range(63), 8'($urandom), 1'($urandom)));
      end
      send_item(scan_req(bytes_q[k], k == span - 1));
      phase_bytes++;
    end
  endtask

  task automatic run_phase(input int ph);
    int          len_choice [9] = '{0, 64, 2, 127, 5, 1, 16, 3, 8};
    logic [63:0] base;
    logic [31:0] off;
    int          eff;
    int          goal;
    int          phase_bytes;
    quiesce();
    case (ph % 4)
      0:       base = '0;
      1:       base = '1;
      2:       base = {$urandom, $urandom};
      default: base = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
    endcase
    case (ph % 5)
      0:       off = 32'h8000_0000;
      1:       off = 32'h7FFF_FFFF;
      2:       off = '1;
      3:       off = '0;
      default: off = $urandom;
    endcase
    if (ph < 3) begin
      src_idle_pct  = 20;
      sink_idle_pct = 50;
    end else if (ph < 6) begin
      src_idle_pct  = 50;
      sink_idle_pct = 20;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
    program_regs(7'(len_choice[ph]), base, off);
    eff = tracker.active_len();
    // Long patterns are mostly wildcards so that matches stay reachable.
    for (int k = 0; k < eff; k++) begin
      send_item(load_req(k, 8'($urandom),
                         (eff > 8) ? ($urandom_range(3) != 0) : ($urandom_range(3) == 0)));
    end
    if (ph == 5) hold_req = LONG_HOLD;
    goal        = (eff >= 16) ? 60 : 25;
    phase_bytes = 0;
    while (phase_bytes < goal) scan_region(eff, phase_bytes);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= wbps_pkg::CFG_PATTERN_LENGTH;
    cfg_wdata_i    <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct  = 20;
    sink_idle_pct = 50;
    run_directed();
    for (int ph = 0; ph < 9; ph++) run_phase(ph);
    quiesce();
    $display("Covered %0d input transactions over directed cases and 9 register settings,",
             item_count);
    $display("checking %0d found and %0d not-found results.",
             tracker.found_seen, tracker.missed_seen);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
